@@ rtl/core/bc_block_texture_decoder_unit_macros.svh @@
// Assertion macros used by the block texture decoder checker.
`ifndef BC_BLOCK_TEXTURE_DECODER_UNIT_MACROS_SVH
`define BC_BLOCK_TEXTURE_DECODER_UNIT_MACROS_SVH

// Same-cycle implication, sampled on clk, off while arst_n is low.
`define BCD_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
	else $error(msg);

// Next-cycle implication, sampled on clk, off while arst_n is low.
`define BCD_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
	else $error(msg);

`endif

@@ rtl/core/bcd_pkg.sv @@
// Package: types, format codes and arithmetic helpers of the block texture decoder.
`timescale 1ns / 1ps
`default_nettype none
package bcd_pkg;

	typedef enum logic [1:0] {
		FMT_BC1 = 2'd0,
		FMT_BC3 = 2'd1,
		FMT_BC4 = 2'd2,
		FMT_BC5 = 2'd3
	} fmt_t;

	localparam int unsigned NumTexels = 16;
	localparam int unsigned NumPairs  = 8;

	typedef logic [7:0][7:0]  chan_pal_t;  // 8 entries, 8 bits each
	typedef logic [3:0][31:0] col_pal_t;   // 4 entries, packed RGBA

	typedef struct packed {
		fmt_t        fmt;
		col_pal_t    col_pal;
		chan_pal_t   a_pal;
		chan_pal_t   b_pal;
		logic [31:0] col_idx;
		logic [47:0] a_sel;
		logic [47:0] b_sel;
	} pal_t;

	function automatic logic [7:0] expand5(input logic [4:0] v);
		return {v, v[4:2]};
	endfunction

	function automatic logic [7:0] expand6(input logic [5:0] v);
		return {v, v[5:4]};
	endfunction

	// x <= 765: x * 683 >> 11 equals x / 3
	function automatic logic [7:0] div3(input logic [9:0] x);
		logic [19:0] p;
		p = 20'(x) * 20'd683;
		return p[18:11];
	endfunction

	// x <= 1275: x * 3277 >> 14 equals x / 5
	function automatic logic [7:0] div5(input logic [10:0] x);
		logic [21:0] p;
		p = 22'(x) * 22'd3277;
		return p[21:14];
	endfunction

	// x <= 1785: x * 2341 >> 14 equals x / 7
	function automatic logic [7:0] div7(input logic [10:0] x);
		logic [21:0] p;
		p = 22'(x) * 22'd2341;
		return p[21:14];
	endfunction

endpackage
`default_nettype wire

@@ rtl/core/bcd_if.sv @@
// Interfaces: compressed block channel and decoded texel channel.
`timescale 1ns / 1ps
`default_nettype none
interface bcd_blk_if;
	logic        valid;
	logic        ready;
	logic [63:0] block_low;
	logic [63:0] block_high;

	modport source (output valid, output block_low, output block_high, input ready);
	modport sink   (input valid, input block_low, input block_high, output ready);
endinterface

interface bcd_tex_if;
	logic        valid;
	logic        ready;
	logic [63:0] texel_pair_0;
	logic [63:0] texel_pair_1;
	logic [63:0] texel_pair_2;
	logic [63:0] texel_pair_3;
	logic [63:0] texel_pair_4;
	logic [63:0] texel_pair_5;
	logic [63:0] texel_pair_6;
	logic [63:0] texel_pair_7;

	modport source (
		output valid, input ready,
		output texel_pair_0, output texel_pair_1, output texel_pair_2, output texel_pair_3,
		output texel_pair_4, output texel_pair_5, output texel_pair_6, output texel_pair_7
	);
	modport sink (
		input valid, output ready,
		input texel_pair_0, input texel_pair_1, input texel_pair_2, input texel_pair_3,
		input texel_pair_4, input texel_pair_5, input texel_pair_6, input texel_pair_7
	);
endinterface
`default_nettype wire

@@ rtl/core/bcd_color_pal.sv @@
// Colour palette builder: RGB565 endpoints to four RGBA entries.
`timescale 1ns / 1ps
`default_nettype none
module bcd_color_pal (
	input  wire logic [63:0]      half,
	output bcd_pkg::col_pal_t     pal
);

	logic [15:0]     c0, c1;
	logic [2:0][7:0] e0, e1;   // B, G, R
	logic [2:0][7:0] mix0, mix1, avg;
	logic [8:0]      avg_sum;
	logic            mode4;

	assign c0    = half[15:0];
	assign c1    = half[31:16];
	assign mode4 = c0 > c1;

	assign e0[0] = bcd_pkg::expand5(c0[4:0]);
	assign e0[1] = bcd_pkg::expand6(c0[10:5]);
	assign e0[2] = bcd_pkg::expand5(c0[15:11]);
	assign e1[0] = bcd_pkg::expand5(c1[4:0]);
	assign e1[1] = bcd_pkg::expand6(c1[10:5]);
	assign e1[2] = bcd_pkg::expand5(c1[15:11]);

	always_comb begin
		avg_sum = '0;
		for (int c = 0; c < 3; c++) begin
			mix0[c] = bcd_pkg::div3({1'b0, e0[c], 1'b0} + {2'b00, e1[c]});
			mix1[c] = bcd_pkg::div3({2'b00, e0[c]} + {1'b0, e1[c], 1'b0});
			avg_sum = {1'b0, e0[c]} + {1'b0, e1[c]};
			avg[c]  = avg_sum[8:1];
		end
	end

	always_comb begin
		pal[0] = {8'hFF, e0[0], e0[1], e0[2]};
		pal[1] = {8'hFF, e1[0], e1[1], e1[2]};
		if (mode4) begin
			pal[2] = {8'hFF, mix0[0], mix0[1], mix0[2]};
			pal[3] = {8'hFF, mix1[0], mix1[1], mix1[2]};
		end else begin
			pal[2] = {8'hFF, avg[0], avg[1], avg[2]};
			pal[3] = '0;   // transparent black
		end
	end

endmodule
`default_nettype wire

@@ rtl/core/bcd_chan_pal.sv @@
// Single-channel palette builder: two 8-bit endpoints to eight entries.
`timescale 1ns / 1ps
`default_nettype none
module bcd_chan_pal (
	input  wire logic [63:0]      half,
	output bcd_pkg::chan_pal_t    pal
);

	logic [7:0]      a0, a1;
	logic [5:0][7:0] d7;
	logic [3:0][7:0] d5;
	logic [10:0]     m7, m5;
	logic            mode8;

	assign a0    = half[7:0];
	assign a1    = half[15:8];
	assign mode8 = a0 > a1;

	always_comb begin
		m7 = '0;
		m5 = '0;
		for (int k = 1; k <= 6; k++) begin
			m7 = 11'(7 - k) * {3'b000, a0} + 11'(k) * {3'b000, a1};
			d7[k-1] = bcd_pkg::div7(m7);
		end
		for (int k = 1; k <= 4; k++) begin
			m5 = 11'(5 - k) * {3'b000, a0} + 11'(k) * {3'b000, a1};
			d5[k-1] = bcd_pkg::div5(m5);
		end
	end

	always_comb begin
		pal[0] = a0;
		pal[1] = a1;
		if (mode8) begin
			for (int k = 0; k < 6; k++) begin
				pal[k+2] = d7[k];
			end
		end else begin
			for (int k = 0; k < 4; k++) begin
				pal[k+2] = d5[k];
			end
			pal[6] = 8'h00;
			pal[7] = 8'hFF;
		end
	end

endmodule
`default_nettype wire

@@ rtl/core/bcd_lane.sv @@
// Texel lane: picks palette entries for one texel and forms its RGBA word.
`timescale 1ns / 1ps
`default_nettype none
module bcd_lane (
	input  wire bcd_pkg::pal_t pal,
	input  wire logic [1:0]    col_idx,
	input  wire logic [2:0]    a_sel,
	input  wire logic [2:0]    b_sel,
	output logic [31:0]        texel
);

	logic [31:0] col;
	logic [7:0]  a, b;

	assign col = pal.col_pal[col_idx];
	assign a   = pal.a_pal[a_sel];
	assign b   = pal.b_pal[b_sel];

	always_comb begin
		unique case (pal.fmt)
			bcd_pkg::FMT_BC1: texel = col;
			bcd_pkg::FMT_BC3: texel = {a, col[23:0]};
			bcd_pkg::FMT_BC4: texel = {8'hFF, a, a, a};
			bcd_pkg::FMT_BC5: texel = {8'hFF, 8'h00, b, a};
		endcase
	end

endmodule
`default_nettype wire

@@ rtl/core/bc_block_texture_decoder_unit.sv @@
// Top level: BC1/BC3/BC4/BC5 4x4 block decoder to 16 RGBA8 texels.
// Usage:
//  - blocks (valid/ready): one compressed block per item, bytes 0..7 on
//    block_low and bytes 8..15 on block_high (high half unused by BC1, BC4).
//  - texels (valid/ready): one item per block, texel_pair_k holds texels 2k
//    (bits 31:0) and 2k+1 (bits 63:32), each R 7:0, G 15:8, B 23:16, A 31:24.
//  - cfg_wr_en/cfg_wr_data: block format, 0 BC1, 1 BC3, 2 BC4, 3 BC5.
//    Write only while the block is idle; the format is sampled when a block
//    is accepted.
// Pipeline: stage 1 registers the colour and channel palettes built from the
// endpoints; stage 2 is the output register, fed by 16 texel lanes that pick
// palette entries, with the merge packing lane results into pairs.
// Throughput is one block per cycle while texels.ready is high; the palette
// divisions are constant-reciprocal multiplies.
// Stall: when texels.ready is low the output holds; stage 1 still takes one
// more block if it is empty, then blocks.ready drops until the output drains.
// Reset (arst_n low): both stages empty, format back to BC1.
`timescale 1ns / 1ps
`default_nettype none
module bc_block_texture_decoder_unit (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       cfg_wr_en,
	input  wire logic [1:0] cfg_wr_data,
	bcd_blk_if.sink         blocks,
	bcd_tex_if.source       texels
);

	bcd_pkg::fmt_t fmt_q;

	// Stage handshake: each stage loads when it is empty or its item moves on.
	logic load_s1, load_s2;
	logic valid_s1, valid_s2;

	assign load_s2      = !valid_s2 || texels.ready;
	assign load_s1      = !valid_s1 || load_s2;
	assign blocks.ready = load_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fmt_q <= bcd_pkg::FMT_BC1;
		end else if (cfg_wr_en) begin
			fmt_q <= bcd_pkg::fmt_t'(cfg_wr_data);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (load_s1) begin
				valid_s1 <= blocks.valid;
			end
			if (load_s2) begin
				valid_s2 <= valid_s1;
			end
		end
	end

	// Palette build ahead of stage 1. BC1 takes its colour part from the low
	// half, BC3 from the high half.
	logic [63:0]          col_half;
	bcd_pkg::col_pal_t    col_pal;
	bcd_pkg::chan_pal_t   a_pal, b_pal;
	bcd_pkg::pal_t        pal_s1;

	assign col_half = (fmt_q == bcd_pkg::FMT_BC1) ? blocks.block_low : blocks.block_high;

	bcd_color_pal u_color_pal (
		.half (col_half),
		.pal  (col_pal)
	);

	bcd_chan_pal u_chan_pal_a (
		.half (blocks.block_low),
		.pal  (a_pal)
	);

	bcd_chan_pal u_chan_pal_b (
		.half (blocks.block_high),
		.pal  (b_pal)
	);

	always_ff @(posedge clk) begin
		if (load_s1 && blocks.valid) begin
			pal_s1.fmt     <= fmt_q;
			pal_s1.col_pal <= col_pal;
			pal_s1.a_pal   <= a_pal;
			pal_s1.b_pal   <= b_pal;
			pal_s1.col_idx <= col_half[63:32];
			pal_s1.a_sel   <= blocks.block_low[63:16];
			pal_s1.b_sel   <= blocks.block_high[63:16];
		end
	end

	// Sixteen texel lanes, one per texel in raster order.
	logic [bcd_pkg::NumTexels-1:0][31:0] texel;

	for (genvar i = 0; i < bcd_pkg::NumTexels; i++) begin : g_lane
		bcd_lane u_lane (
			.pal     (pal_s1),
			.col_idx (pal_s1.col_idx[2*i +: 2]),
			.a_sel   (pal_s1.a_sel[3*i +: 3]),
			.b_sel   (pal_s1.b_sel[3*i +: 3]),
			.texel   (texel[i])
		);
	end

	// Merge: pack lane pairs into the output register.
	logic [bcd_pkg::NumPairs-1:0][63:0] pair_s2;

	always_ff @(posedge clk) begin
		if (load_s2 && valid_s1) begin
			for (int k = 0; k < bcd_pkg::NumPairs; k++) begin
				pair_s2[k] <= {texel[2*k+1], texel[2*k]};
			end
		end
	end

	assign texels.valid        = valid_s2;
	assign texels.texel_pair_0 = pair_s2[0];
	assign texels.texel_pair_1 = pair_s2[1];
	assign texels.texel_pair_2 = pair_s2[2];
	assign texels.texel_pair_3 = pair_s2[3];
	assign texels.texel_pair_4 = pair_s2[4];
	assign texels.texel_pair_5 = pair_s2[5];
	assign texels.texel_pair_6 = pair_s2[6];
	assign texels.texel_pair_7 = pair_s2[7];

endmodule
`default_nettype wire

@@ rtl/core/bcd_checker.sv @@
// Port-level checker for the block texture decoder, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
`include "bc_block_texture_decoder_unit_macros.svh"
module bcd_checker (
	input wire logic         clk,
	input wire logic         arst_n,
	input wire logic         in_valid,
	input wire logic         in_ready,
	input wire logic         out_valid,
	input wire logic         out_ready,
	input wire logic [511:0] out_payload
);

	// A stalled result stays put.
	`BCD_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_payload), "texel item changed while stalled")

	// With the output register empty the pipeline can always take a block.
	`BCD_ASSERT_NOW(a_ready_when_empty, !out_valid, in_ready, "blocks not ready with empty output")

	// Every accepted block shows up on the output after the stage 1 and output registers.
	`BCD_ASSERT_NOW(a_latency, in_valid && in_ready, ##2 out_valid, "no texel item two cycles after accept")

endmodule

bind bc_block_texture_decoder_unit bcd_checker u_bcd_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.in_valid    (blocks.valid),
	.in_ready    (blocks.ready),
	.out_valid   (texels.valid),
	.out_ready   (texels.ready),
	.out_payload ({texels.texel_pair_7, texels.texel_pair_6, texels.texel_pair_5,
		texels.texel_pair_4, texels.texel_pair_3, texels.texel_pair_2,
		texels.texel_pair_1, texels.texel_pair_0})
);
`default_nettype wire
